>>> rtl/core/lwsh_pkg.sv
// Shared constants for the interpolating table waveshaper.
package lwsh_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W = 4;
	localparam int INDEX_W = 11;
	localparam int MAX_SEGMENTS_LOG2_DEF = 10;
	localparam logic [CFG_W-1:0] SEGMENTS_LOG2_RESET = 4'd10;

	localparam int IN_TDATA_W = 48;
	localparam int OUT_TDATA_W = 16;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_SHAPE = 1'b1;

endpackage

>>> rtl/core/lwsh_ram.sv
// Generic RAM with one write port and two registered read ports.
module lwsh_ram #(
	parameter int WIDTH = lwsh_pkg::SAMPLE_W,
	parameter int DEPTH = 1025,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

>>> rtl/core/lerp_table_waveshaper.sv
// Top level of the interpolating table waveshaper.
//
// The block shapes signed 16-bit samples through a transfer table of
// 2^MAX_SEGMENTS_LOG2+1 signed Q15 entries held in a dual-read RAM. A write
// item (tuser low) loads one entry and gives no result; a sample item
// (tuser high) reads the two neighboring entries picked by its top bits and
// interpolates between them with its low bits. The block takes one item per
// clock cycle while the output does not stall; a sample's result comes from
// the RAM read at the accept edge, then the multiply, then the add into the
// output register, and a stalled output holds the whole pipeline.
// The table contents are undefined after reset, so every entry must be
// loaded before a sample reaches it. The user writes segments_log2 only while
// the block is idle; the block itself does not enforce this.
module lerp_table_waveshaper #(
	parameter int MAX_SEGMENTS_LOG2 = lwsh_pkg::MAX_SEGMENTS_LOG2_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [lwsh_pkg::CFG_W-1:0]         cfg_wr_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// entry_index [10:0], entry_value [26:11], sample_in [42:27], zeros [47:43]
	input  logic [lwsh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// mode
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// sample_out [15:0]
	output logic [lwsh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	localparam int TABLE_DEPTH = (1 << MAX_SEGMENTS_LOG2) + 1;
	localparam int AW = MAX_SEGMENTS_LOG2 + 1;

	logic [lwsh_pkg::CFG_W-1:0] seg_q;

	logic en1, en2, en3;
	logic accept;
	logic [10:0] entry_index;
	logic [15:0] entry_value;
	logic [15:0] sample_in;

	logic [lwsh_pkg::CFG_W-1:0] seg_k;
	logic [4:0] shift_c;
	logic [15:0] u_c;
	logic [15:0] a_c;
	logic [16:0] mask_c;
	logic [15:0] frac_c;
	logic [31:0] idx_wide;
	logic wr_ok;
	logic ram_we;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	logic [15:0] rdata_a;
	logic [15:0] rdata_b;

	logic v_s1, v_s2, v_s3;
	logic [4:0] shift_s1, shift_s2;
	logic [15:0] frac_s1;
	logic signed [15:0] ya_s2;
	logic signed [33:0] prod_s2;
	logic [15:0] out_s3;

	logic signed [16:0] diff_c;
	logic signed [16:0] fracs_c;
	logic signed [33:0] prod_c;
	logic signed [33:0] step_c;
	logic signed [33:0] sum_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= lwsh_pkg::SEGMENTS_LOG2_RESET;
		end else if (cfg_wr_en) begin
			seg_q <= cfg_wr_data;
		end
	end

	// A stage moves on when the stage after it is empty or moving too.
	assign en3 = !v_s3 || m_axis_tready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;
	assign accept = s_axis_tvalid && en1;

	assign entry_index = s_axis_tdata[10:0];
	assign entry_value = s_axis_tdata[26:11];
	assign sample_in = s_axis_tdata[42:27];

	// Address and fraction split of the offset sample.
	always_comb begin
		if (seg_q > lwsh_pkg::CFG_W'(MAX_SEGMENTS_LOG2)) begin
			seg_k = lwsh_pkg::CFG_W'(MAX_SEGMENTS_LOG2);
		end else begin
			seg_k = seg_q;
		end
		shift_c = 5'd16 - {1'b0, seg_k};
		u_c = {~sample_in[15], sample_in[14:0]};
		a_c = u_c >> shift_c;
		mask_c = (17'd1 << shift_c) - 17'd1;
		frac_c = u_c & mask_c[15:0];
	end

	assign rd_addr_a = a_c[AW-1:0];
	assign rd_addr_b = rd_addr_a + AW'(1);

	assign idx_wide = 32'(entry_index);
	assign wr_ok = idx_wide < 32'(TABLE_DEPTH);
	assign wr_addr = idx_wide[AW-1:0];
	assign ram_we = accept && (s_axis_tuser == lwsh_pkg::MODE_WRITE) && wr_ok;

	// A write lands at its accept edge, so a sample in the next cycle
	// already reads the new entry; no forwarding path is needed.
	lwsh_ram #(
		.WIDTH(lwsh_pkg::SAMPLE_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (wr_addr),
		.wdata   (entry_value),
		.re      (accept),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept && (s_axis_tuser == lwsh_pkg::MODE_SHAPE);
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shift_s1 <= shift_c;
			frac_s1 <= frac_c;
		end
	end

	assign diff_c = $signed({rdata_b[15], rdata_b}) - $signed({rdata_a[15], rdata_a});
	assign fracs_c = $signed({1'b0, frac_s1});
	assign prod_c = 34'(diff_c) * 34'(fracs_c);

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			prod_s2 <= prod_c;
			ya_s2 <= $signed(rdata_a);
			shift_s2 <= shift_s1;
		end
	end

	// Arithmetic shift floors the scaled step; the sum stays between the
	// two entries, so its low 16 bits are the whole result.
	assign step_c = prod_s2 >>> shift_s2;
	assign sum_c = step_c + 34'(ya_s2);

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			out_s3 <= sum_c[15:0];
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata = out_s3;

`ifndef SYNTHESIS
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser == lwsh_pkg::MODE_WRITE) |=> !v_s1)
		else $error("write item entered the shaping pipeline");

	a_sample_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser == lwsh_pkg::MODE_SHAPE) |=> v_s1)
		else $error("sample item lost at pipeline entry");

	a_addr_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser == lwsh_pkg::MODE_SHAPE)
		|-> (32'(rd_addr_b) < 32'(TABLE_DEPTH)))
		else $error("upper entry address beyond the table");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en2) |=> (v_s1 && $stable(frac_s1) && $stable(rdata_a)
		&& $stable(rdata_b)))
		else $error("stalled first stage lost its item");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en3) |=> (v_s2 && $stable(prod_s2) && $stable(ya_s2)))
		else $error("stalled product stage lost its item");
`endif

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the interpolating table waveshaper.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lwsh_pkg::*;

	localparam int CURVE_DEPTH = (1 << MAX_SEGMENTS_LOG2_DEF) + 1;
	localparam int ITEM_BUDGET = 1460;
	localparam int PHASE_ITEMS = 120;
	localparam int HOLD_CYCLES = 400;

	// Keeps its own copy of the transfer curve and the pending shaped samples.
	class shaper_scoreboard;
		logic [SAMPLE_W-1:0] curve [0:CURVE_DEPTH-1];
		logic [CFG_W-1:0] seg_log2;
		logic [SAMPLE_W-1:0] expected_out [$];
		int unsigned mismatches;
		int unsigned loaded;
		int unsigned shaped;

		function new();
			foreach (curve[i])
				curve[i] = '0;
			seg_log2 = SEGMENTS_LOG2_RESET;
			mismatches = 0;
			loaded = 0;
			shaped = 0;
		endfunction

		function void set_segments(logic [CFG_W-1:0] v);
			seg_log2 = v;
		endfunction

		function logic [SAMPLE_W-1:0] interpolate(logic [SAMPLE_W-1:0] smp);
			int unsigned k;
			int unsigned shift;
			int unsigned u;
			int unsigned seg;
			int unsigned frac;
			longint ya;
			longint yb;
			longint delta;
			k = (seg_log2 > MAX_SEGMENTS_LOG2_DEF) ? MAX_SEGMENTS_LOG2_DEF : seg_log2;
			shift = SAMPLE_W - k;
			u = smp ^ 16'h8000;
			seg = u >> shift;
			frac = u - (seg << shift);
			ya = longint'($signed(curve[seg]));
			yb = longint'($signed(curve[seg + 1]));
			// Arithmetic shift of a signed product rounds toward minus infinity.
			delta = ((yb - ya) * longint'(frac)) >>> shift;
			return 16'(ya + delta);
		endfunction

		function void note_input(logic mode, logic [INDEX_W-1:0] idx,
				logic [SAMPLE_W-1:0] val, logic [SAMPLE_W-1:0] smp);
			if (mode == MODE_WRITE) begin
				if (idx < CURVE_DEPTH) begin
					curve[idx] = val;
					loaded++;
				end
			end else begin
				expected_out.push_back(interpolate(smp));
				shaped++;
			end
		endfunction

		function void check_output(logic [SAMPLE_W-1:0] got);
			logic [SAMPLE_W-1:0] want;
			if (expected_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected sample_out %h", $time, got);
				return;
			end
			want = expected_out.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: sample_out expected %h got %h", $time, want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	shaper_scoreboard sb = new();
	bit entry_loaded [0:CURVE_DEPTH-1];
	int unsigned items_sent = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned active_k = MAX_SEGMENTS_LOG2_DEF;

	lerp_table_waveshaper dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_input(s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[26:11],
				s_axis_tdata[42:27]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_output(m_axis_tdata);
	end

	// Output side: random stalls, plus one long hold early on so the block backs up.
	initial begin
		int unsigned hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && items_sent >= 200) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_item(input logic mode, input logic [INDEX_W-1:0] idx,
			input logic [SAMPLE_W-1:0] val, input logic [SAMPLE_W-1:0] smp);
		if (items_sent < ITEM_BUDGET / 3) begin
			tx_idle_pct = 29;
			rx_idle_pct = 57;
		end else if (items_sent < 2 * ITEM_BUDGET / 3) begin
			tx_idle_pct = 57;
			rx_idle_pct = 29;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {5'b0, smp, val, idx};
		do @(posedge clk); while (!s_axis_tready);
		if (mode == MODE_WRITE && idx < CURVE_DEPTH)
			entry_loaded[idx] = 1'b1;
		items_sent++;
	endtask

	task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
		push_item(MODE_WRITE, idx, val, 16'($urandom));
	endtask

	// Loads whichever neighbors the sample reads that are still unwritten.
	task automatic shape_sample(input logic [SAMPLE_W-1:0] smp);
		int unsigned pos;
		pos = 32'(smp ^ 16'h8000) >> (SAMPLE_W - active_k);
		if (!entry_loaded[pos])
			load_entry(pos[INDEX_W-1:0], pick_value());
		if (!entry_loaded[pos + 1])
			load_entry(11'(pos + 1), pick_value());
		push_item(MODE_SHAPE, 11'($urandom), 16'($urandom), smp);
	endtask

	task automatic random_item();
		int unsigned roll;
		int unsigned pos;
		logic [SAMPLE_W-1:0] smp;
		roll = $urandom_range(99);
		if (roll < 65) begin
			shape_sample(pick_sample());
		end else if (roll < 85) begin
			load_entry(11'($urandom_range(1 << active_k)), pick_value());
		end else if (roll < 92) begin
			load_entry(11'($urandom_range(2047, CURVE_DEPTH)), pick_value());
		end else begin
			// Rewrite both neighbors right before the sample that reads them.
			smp = pick_sample();
			pos = 32'(smp ^ 16'h8000) >> (SAMPLE_W - active_k);
			load_entry(pos[INDEX_W-1:0], pick_value());
			load_entry(11'(pos + 1), pick_value());
			push_item(MODE_SHAPE, 11'($urandom), 16'($urandom), smp);
		end
	endtask

	// Waits until the block is empty, then writes segments_log2.
	task automatic drain_and_configure(input logic [CFG_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_segments(v);
		active_k = (v > MAX_SEGMENTS_LOG2_DEF) ? MAX_SEGMENTS_LOG2_DEF : v;
		@(posedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] cfg_plan [8];
		logic [CFG_W-1:0] cfg_value;
		int unsigned phase_start;
		cfg_plan = '{4'd0, 4'd15, 4'd3, 4'd1, 4'd10, 4'd12, 4'd6, 4'd7};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_WRITE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		drain_and_configure(SEGMENTS_LOG2_RESET);
		// Directed part with the full 1024-segment table: extreme entries
		// side by side, both ends of the sample range, the midpoint, and
		// writes beyond the table that must be dropped.
		load_entry(11'd0, 16'h8000);
		load_entry(11'd1, 16'h7FFF);
		load_entry(11'd1023, 16'h7FFF);
		load_entry(11'd1024, 16'h8000);
		load_entry(11'd511, 16'hFFFF);
		load_entry(11'd512, 16'h0000);
		load_entry(11'd513, 16'h4000);
		load_entry(11'd1025, 16'h1234);
		load_entry(11'd2047, 16'hFFFF);
		shape_sample(16'h8000);
		shape_sample(16'h803F);
		shape_sample(16'h7FFF);
		shape_sample(16'hFFFF);
		shape_sample(16'h0000);
		shape_sample(16'h0001);
		// A sample that reads entries written in the two items just before it.
		load_entry(11'd2, 16'd12345);
		load_entry(11'd3, -16'sd12345);
		shape_sample(16'h809F);

		for (int p = 0; p < 12; p++) begin
			cfg_value = (p < 8) ? cfg_plan[p] : 4'($urandom_range(15));
			drain_and_configure(cfg_value);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				random_item();
		end

		s_axis_tvalid <= 1'b0;
		while (sb.expected_out.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Loaded %0d table entries and shaped %0d samples in %0d items,",
			sb.loaded, sb.shaped, items_sent);
		$display("over 13 segment settings from 0 to 15, with a %0d-cycle output hold.",
			HOLD_CYCLES);
		if (sb.mismatches == 0 && sb.expected_out.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/lwsh_pkg.sv
rtl/core/lwsh_ram.sv
rtl/core/lerp_table_waveshaper.sv
verif/testbench.sv
